// File: hw/rtl/vrd_pkg.sv
// Shared constants, types and the arctangent table for the degree-angle vector rotator.
`default_nettype none

package vrd_pkg;

   // Build options.
   localparam int CORDIC_STAGES   = 18;
   localparam int ANGLE_FRAC_BITS = 6;

   // Arctangent table length and the number of micro-rotations really performed.
   localparam int TABLE_LEN    = 24;
   localparam int CORDIC_STEPS = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

   // Port widths.
   localparam int XY_W  = 16;
   localparam int ANG_W = 24;
   localparam int OUT_W = 17;

   // Largest output magnitude of a rotated input vector.
   localparam int OUT_MAX = 46341;

   // Front stages ahead of the micro-rotation stages.
   localparam int FRONT_STAGES = 4;

   // Angles in degrees with the fraction bits.
   localparam int FULL_DEG    = 360 << ANGLE_FRAC_BITS;
   localparam int HALF_DEG    = 180 << ANGLE_FRAC_BITS;
   localparam int QUARTER_DEG = 90 << ANGLE_FRAC_BITS;

   // Angle magnitude and reduced-angle widths.
   localparam int MAG_W  = ANG_W;
   localparam int FULL_W = $clog2(FULL_DEG + 1);
   localparam int RED_W  = FULL_W + 1;
   localparam int QM_W   = $clog2(QUARTER_DEG + 1);
   localparam int QR_W   = QM_W + 1;

   // Reciprocal of a full turn for the modulo reduction.
   localparam int              RECIP_SH = 32;
   localparam longint unsigned RECIP    = (64'd1 << RECIP_SH) / FULL_DEG;
   localparam int              RECIP_W  = $clog2(RECIP + 1);
   localparam int              Q_W      = MAG_W + RECIP_W - RECIP_SH;

   // Degrees to radians in Q40, applied with a rounding shift.
   localparam int              D2R_W   = 35;
   localparam logic [D2R_W-1:0] D2R_Q40 = 35'd19190098069;
   localparam int              RAD_SH  = 8 + ANGLE_FRAC_BITS;
   localparam int              ZP_W    = QM_W + D2R_W + 1;

   // CORDIC datapath widths; vector values are Q32.
   localparam int Q_FRAC = 32;
   localparam int CW     = 50;
   localparam int Z_W    = 36;
   localparam int ATAN_W = 32;

   // CORDIC gain compensation in Q32.
   localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

   typedef logic signed [CW-1:0]  coord_type;
   typedef logic signed [Z_W-1:0] angle_type;

   // Arctangent of 2^-i in Q32 radians.
   function automatic logic [ATAN_W-1:0] atan_q32(input int idx);
      logic [ATAN_W-1:0] val;
      case (idx)
         0:  val = 32'd3373259426;
         1:  val = 32'd1991351318;
         2:  val = 32'd1052175346;
         3:  val = 32'd534100635;
         4:  val = 32'd268086748;
         5:  val = 32'd134174063;
         6:  val = 32'd67103403;
         7:  val = 32'd33553749;
         8:  val = 32'd16777131;
         9:  val = 32'd8388597;
         10: val = 32'd4194303;
         11: val = 32'd2097152;
         12: val = 32'd1048576;
         13: val = 32'd524288;
         14: val = 32'd262144;
         15: val = 32'd131072;
         16: val = 32'd65536;
         17: val = 32'd32768;
         18: val = 32'd16384;
         19: val = 32'd8192;
         20: val = 32'd4096;
         21: val = 32'd2048;
         22: val = 32'd1024;
         23: val = 32'd512;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/vector_rotate_degrees_core.sv
// Vector rotation by an angle in degrees: angle reduction front end and unrolled CORDIC pipeline.
// An item passes the front stages, the micro-rotation stages and the output register in turn.
// Throughput: one item per cycle barring stalls; each stage has its own register.
// Bubbles close up under a result stall; input stalls only when every stage holds an item.
// Reset: synchronous, active high; clears all stage valid bits, payload registers are not reset.
`default_nettype none

module vector_rotate_degrees_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [vrd_pkg::XY_W-1:0]     req_x_in,
   input  logic signed [vrd_pkg::XY_W-1:0]     req_y_in,
   input  logic signed [vrd_pkg::ANG_W-1:0]    req_angle_deg,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [vrd_pkg::OUT_W-1:0]    rsp_x_out,
   output logic signed [vrd_pkg::OUT_W-1:0]    rsp_y_out
);
   import vrd_pkg::*;

   localparam int NSTG = FRONT_STAGES + CORDIC_STAGES + 1;
   localparam int OSTG = NSTG - 1;

   localparam logic [MAG_W-1:0]        FULL_M     = MAG_W'(FULL_DEG);
   localparam logic [RECIP_W-1:0]      RECIP_V    = RECIP_W'(RECIP);
   localparam logic signed [RED_W-1:0] FULL_S     = RED_W'(FULL_DEG);
   localparam logic signed [RED_W-1:0] HALF_S     = RED_W'(HALF_DEG);
   localparam logic signed [RED_W-1:0] NHALF_S    = -HALF_S;
   localparam logic signed [RED_W-1:0] QUARTER_S  = RED_W'(QUARTER_DEG);
   localparam logic signed [RED_W-1:0] NQUARTER_S = -QUARTER_S;
   localparam logic [ZP_W-1:0]         RAD_HALF   = ZP_W'(1) << (RAD_SH - 1);
   localparam coord_type               TRUNC_BIAS = (CW'(1) <<< Q_FRAC) - CW'(1);

   // Stage valid bits and per-stage advance enables.
   logic [NSTG-1:0] vld_ff, vld_in, adv;

   // A stage loads when the result side takes, or when some stage at or after it is empty.
   for (genvar k = 0; k < NSTG; k++) begin : g_adv
      assign adv[k] = !rsp_stall || !(&vld_ff[NSTG-1:k]);
   end

   always_comb begin
      vld_in[0] = adv[0] ? req_valid : vld_ff[0];
      for (int k = 1; k < NSTG; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = vld_ff[OSTG];

   // Stage 1: angle magnitude and quotient estimate by a full turn.
   logic signed [ANG_W:0]         ang_ext;
   logic [MAG_W-1:0]              mag1_in, mag1_ff;
   logic [MAG_W+RECIP_W-1:0]      quot_prod;
   logic [Q_W-1:0]                q1_in, q1_ff;
   logic                          neg1_ff;
   logic signed [XY_W-1:0]        x1_ff, y1_ff;

   always_comb begin
      ang_ext   = (ANG_W + 1)'(req_angle_deg);
      mag1_in   = req_angle_deg[ANG_W-1] ? MAG_W'(-ang_ext) : MAG_W'(ang_ext);
      quot_prod = (MAG_W + RECIP_W)'(mag1_in) * (MAG_W + RECIP_W)'(RECIP_V);
      q1_in     = Q_W'(quot_prod >> RECIP_SH);
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         mag1_ff <= mag1_in;
         q1_ff   <= q1_in;
         neg1_ff <= req_angle_deg[ANG_W-1];
         x1_ff   <= req_x_in;
         y1_ff   <= req_y_in;
      end
   end

   // Stage 2: remainder with one correction, sign of the dividend restored.
   logic [Q_W+FULL_W-1:0]         rem_prod;
   logic [MAG_W-1:0]              rem_raw, rem_fix;
   logic signed [RED_W-1:0]       rem_s;
   logic signed [RED_W-1:0]       red2_in, red2_ff;
   logic signed [XY_W-1:0]        x2_ff, y2_ff;

   always_comb begin
      rem_prod = (Q_W + FULL_W)'(q1_ff) * (Q_W + FULL_W)'(FULL_DEG);
      rem_raw  = mag1_ff - MAG_W'(rem_prod);
      rem_fix  = (rem_raw >= FULL_M) ? (rem_raw - FULL_M) : rem_raw;
      rem_s    = RED_W'(rem_fix);
      red2_in  = neg1_ff ? -rem_s : rem_s;
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         red2_ff <= red2_in;
         x2_ff   <= x1_ff;
         y2_ff   <= y1_ff;
      end
   end

   // Stage 3: fold into (-180, 180], then take out quarter turns by swap and negate.
   logic signed [RED_W-1:0]       fold_a, quad_a;
   logic signed [OUT_W-1:0]       x2_ext, y2_ext;
   logic signed [OUT_W-1:0]       x3_in, y3_in, x3_ff, y3_ff;
   logic signed [QR_W-1:0]        res3_in, res3_ff;
   logic                          byp3_in, byp3_ff;

   always_comb begin
      x2_ext = OUT_W'(x2_ff);
      y2_ext = OUT_W'(y2_ff);
      if (red2_ff > HALF_S) begin
         fold_a = red2_ff - FULL_S;
      end else if (red2_ff <= NHALF_S) begin
         fold_a = red2_ff + FULL_S;
      end else begin
         fold_a = red2_ff;
      end
      if (fold_a > QUARTER_S) begin
         x3_in  = -y2_ext;
         y3_in  = x2_ext;
         quad_a = fold_a - QUARTER_S;
      end else if (fold_a < NQUARTER_S) begin
         x3_in  = y2_ext;
         y3_in  = -x2_ext;
         quad_a = fold_a + QUARTER_S;
      end else begin
         x3_in  = x2_ext;
         y3_in  = y2_ext;
         quad_a = fold_a;
      end
      res3_in = QR_W'(quad_a);
      byp3_in = (quad_a == '0);
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         x3_ff   <= x3_in;
         y3_ff   <= y3_in;
         res3_ff <= res3_in;
         byp3_ff <= byp3_in;
      end
   end

   // Stage 4: residual to Q32 radians, vector scaled by the CORDIC gain unless the residual is zero.
   logic [QM_W-1:0]               mag4;
   logic [ZP_W-1:0]               zprod, zround;
   angle_type                     zq, z4_in, z4_ff;
   coord_type                     cx4_in, cy4_in, cx4_ff, cy4_ff;
   logic                          byp4_ff;

   always_comb begin
      mag4   = res3_ff[QR_W-1] ? QM_W'(-res3_ff) : QM_W'(res3_ff);
      zprod  = ZP_W'(mag4) * ZP_W'(D2R_Q40);
      zround = zprod + RAD_HALF;
      zq     = Z_W'(zround >> RAD_SH);
      z4_in  = res3_ff[QR_W-1] ? -zq : zq;
      if (byp3_ff) begin
         cx4_in = CW'($signed({x3_ff, {Q_FRAC{1'b0}}}));
         cy4_in = CW'($signed({y3_ff, {Q_FRAC{1'b0}}}));
      end else begin
         cx4_in = x3_ff * $signed({1'b0, GAIN_Q32});
         cy4_in = y3_ff * $signed({1'b0, GAIN_Q32});
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         z4_ff   <= z4_in;
         cx4_ff  <= cx4_in;
         cy4_ff  <= cy4_in;
         byp4_ff <= byp3_ff;
      end
   end

   // Micro-rotation stages, one register stage each.
   coord_type                     cx_ff [CORDIC_STAGES];
   coord_type                     cy_ff [CORDIC_STAGES];
   angle_type                     z_ff  [CORDIC_STAGES];
   logic [CORDIC_STAGES-1:0]      byp_ff;

   for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_rot
      coord_type cx_prev, cy_prev, cx_in, cy_in;
      angle_type z_prev, z_in;
      logic      byp_prev;

      if (gi == 0) begin : g_first
         assign cx_prev  = cx4_ff;
         assign cy_prev  = cy4_ff;
         assign z_prev   = z4_ff;
         assign byp_prev = byp4_ff;
      end else begin : g_next
         assign cx_prev  = cx_ff[gi-1];
         assign cy_prev  = cy_ff[gi-1];
         assign z_prev   = z_ff[gi-1];
         assign byp_prev = byp_ff[gi-1];
      end

      // Rotate toward zero residual angle; exact quarter turns pass unchanged.
      always_comb begin
         if ((gi < CORDIC_STEPS) && !byp_prev) begin
            if (!z_prev[Z_W-1]) begin
               cx_in = cx_prev - (cy_prev >>> gi);
               cy_in = cy_prev + (cx_prev >>> gi);
               z_in  = z_prev - Z_W'(atan_q32(gi));
            end else begin
               cx_in = cx_prev + (cy_prev >>> gi);
               cy_in = cy_prev - (cx_prev >>> gi);
               z_in  = z_prev + Z_W'(atan_q32(gi));
            end
         end else begin
            cx_in = cx_prev;
            cy_in = cy_prev;
            z_in  = z_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[FRONT_STAGES+gi]) begin
            cx_ff[gi]  <= cx_in;
            cy_ff[gi]  <= cy_in;
            z_ff[gi]   <= z_in;
            byp_ff[gi] <= byp_prev;
         end
      end
   end

   // Output register: truncate Q32 toward zero.
   coord_type                     cx_last, cy_last, cx_biased, cy_biased;
   logic signed [OUT_W-1:0]       x_out_in, y_out_in, x_out_ff, y_out_ff;

   always_comb begin
      cx_last   = cx_ff[CORDIC_STAGES-1];
      cy_last   = cy_ff[CORDIC_STAGES-1];
      cx_biased = cx_last + (cx_last[CW-1] ? TRUNC_BIAS : '0);
      cy_biased = cy_last + (cy_last[CW-1] ? TRUNC_BIAS : '0);
      x_out_in  = cx_biased[Q_FRAC +: OUT_W];
      y_out_in  = cy_biased[Q_FRAC +: OUT_W];
   end

   always_ff @(posedge clock) begin
      if (adv[OSTG]) begin
         x_out_ff <= x_out_in;
         y_out_ff <= y_out_in;
      end
   end

   assign rsp_x_out = x_out_ff;
   assign rsp_y_out = y_out_ff;

endmodule

`default_nettype wire

// File: hw/rtl/vrd_checker.sv
// Port-level assertions for the vector rotator and the bind that attaches them.
`default_nettype none

module vrd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic signed [vrd_pkg::XY_W-1:0]     req_x_in,
   input logic signed [vrd_pkg::XY_W-1:0]     req_y_in,
   input logic signed [vrd_pkg::ANG_W-1:0]    req_angle_deg,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [vrd_pkg::OUT_W-1:0]    rsp_x_out,
   input logic signed [vrd_pkg::OUT_W-1:0]    rsp_y_out
);
   import vrd_pkg::*;

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Input backs up only when a result is present and held by the receiver.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the output side can move");

   // A stalled result holds until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_x_out) && $stable(rsp_y_out)))
      else $error("stalled result changed");

   // Each result component stays within OUT_MAX, the largest magnitude of a rotated input vector.
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_x_out >= -OUT_MAX) && (rsp_x_out <= OUT_MAX) &&
                     (rsp_y_out >= -OUT_MAX) && (rsp_y_out <= OUT_MAX)))
      else $error("result component out of range");

endmodule

bind vector_rotate_degrees_core vrd_checker u_vrd_checker (.*);

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the degree-angle vector rotator core.
`default_nettype none

module tb;

   localparam int XY_W  = vrd_pkg::XY_W;
   localparam int ANG_W = vrd_pkg::ANG_W;
   localparam int OUT_W = vrd_pkg::OUT_W;

   // Angle units in degrees with the fraction bits.
   localparam longint TURN_FULL    = longint'(360) << vrd_pkg::ANGLE_FRAC_BITS;
   localparam longint TURN_HALF    = longint'(180) << vrd_pkg::ANGLE_FRAC_BITS;
   localparam longint TURN_QUARTER = longint'(90) << vrd_pkg::ANGLE_FRAC_BITS;
   localparam int     DEG_ONE      = 1 << vrd_pkg::ANGLE_FRAC_BITS;

   // Fixed-point constants of the rotation: degrees to Q40 radians and the CORDIC gain in Q32.
   localparam longint DEG_TO_RAD_Q40 = 64'sd19190098069;
   localparam longint GAIN_Q32       = 64'sd2608131496;
   localparam int     RAD_SHIFT      = 8 + vrd_pkg::ANGLE_FRAC_BITS;
   localparam int     ROTATE_STEPS   = vrd_pkg::CORDIC_STEPS;

   localparam int PIPE_LATENCY = 23;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PRINT_LIMIT  = 30;

   typedef struct {
      logic signed [XY_W-1:0]  x_in;
      logic signed [XY_W-1:0]  y_in;
      logic signed [ANG_W-1:0] angle;
      logic signed [OUT_W-1:0] x_out;
      logic signed [OUT_W-1:0] y_out;
   } rotation_type;

   logic                    clock         = 1'b0;
   logic                    reset         = 1'b1;
   logic                    req_valid     = 1'b0;
   logic                    req_stall;
   logic signed [XY_W-1:0]  req_x_in      = '0;
   logic signed [XY_W-1:0]  req_y_in      = '0;
   logic signed [ANG_W-1:0] req_angle_deg = '0;
   logic                    rsp_valid;
   logic                    rsp_stall     = 1'b0;
   logic signed [OUT_W-1:0] rsp_x_out;
   logic signed [OUT_W-1:0] rsp_y_out;

   rotation_type pending_rotations[$];
   longint       atan_rad_q32[0:23];

   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int stall_hold_left = 0;
   int cycle_count     = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int input_stalls    = 0;
   int mismatch_count  = 0;

   vector_rotate_degrees_core DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_x_in      (req_x_in),
      .req_y_in      (req_y_in),
      .req_angle_deg (req_angle_deg),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_x_out     (rsp_x_out),
      .rsp_y_out     (rsp_y_out)
   );

   always #5 clock = ~clock;

   // Arctangent of 2^-i in Q32 radians, rounded to nearest.
   initial begin
      for (int i = 0; i < 24; i++) begin
         atan_rad_q32[i] = longint'($atan(2.0 ** (-i)) * 4294967296.0);
      end
   end

   // Expected rotation: exact quarter turns first, then CORDIC on the residual angle.
   function automatic void predict_rotation(
      input  logic signed [XY_W-1:0]  vx,
      input  logic signed [XY_W-1:0]  vy,
      input  logic signed [ANG_W-1:0] ang,
      output logic signed [OUT_W-1:0] ox,
      output logic signed [OUT_W-1:0] oy
   );
      longint px, py, swap, deg, zmag, z, cx, cy, dx, dy, rx, ry;
      int stage;
      px  = vx;
      py  = vy;
      deg = ang;

      // Reduce modulo a full turn, keeping the dividend sign, then fold into (-180, 180].
      deg = deg % TURN_FULL;
      if (deg > TURN_HALF) begin
         deg -= TURN_FULL;
      end else if (deg <= -TURN_HALF) begin
         deg += TURN_FULL;
      end

      // A quarter turn is taken exactly by swapping and negating.
      if (deg > TURN_QUARTER) begin
         swap = px; px = -py; py = swap; deg -= TURN_QUARTER;
      end else if (deg < -TURN_QUARTER) begin
         swap = px; px = py; py = -swap; deg += TURN_QUARTER;
      end

      if (deg == 0) begin
         rx = px;
         ry = py;
      end else begin
         // Residual degrees to Q32 radians, rounding half away from zero.
         zmag = ((deg < 0 ? -deg : deg) * DEG_TO_RAD_Q40 + (longint'(1) << (RAD_SHIFT - 1)))
                >> RAD_SHIFT;
         z  = (deg < 0) ? -zmag : zmag;
         cx = px * GAIN_Q32;
         cy = py * GAIN_Q32;
         for (stage = 0; stage < ROTATE_STEPS; stage++) begin
            dx = cy >>> stage;
            dy = cx >>> stage;
            if (z >= 0) begin
               cx -= dx; cy += dy; z -= atan_rad_q32[stage];
            end else begin
               cx += dx; cy -= dy; z += atan_rad_q32[stage];
            end
         end
         // Truncate the Q32 values toward zero.
         rx = (cx >= 0) ? (cx >>> 32) : -((-cx) >>> 32);
         ry = (cy >= 0) ? (cy >>> 32) : -((-cy) >>> 32);
      end
      ox = rx[OUT_W-1:0];
      oy = ry[OUT_W-1:0];
   endfunction

   // Each mismatch prints one line, up to a cap, and is always counted.
   task automatic note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("ERROR @%0t: %s", $time, what);
      end
   endtask

   // Offer one vector, hold it until the transfer happens, then record the expected result.
   task automatic offer_vector(input int vx, input int vy, input int ang);
      rotation_type            entry;
      logic signed [XY_W-1:0]  sx;
      logic signed [XY_W-1:0]  sy;
      logic signed [ANG_W-1:0] sa;
      sx = XY_W'(vx);
      sy = XY_W'(vy);
      sa = ANG_W'(ang);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_x_in      <= sx;
      req_y_in      <= sy;
      req_angle_deg <= sa;
      @(posedge clock);
      while (req_stall) begin
         input_stalls++;
         @(posedge clock);
      end
      entry.x_in  = sx;
      entry.y_in  = sy;
      entry.angle = sa;
      predict_rotation(sx, sy, sa, entry.x_out, entry.y_out);
      pending_rotations.push_back(entry);
      items_sent++;
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic wait_all_returned();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_rotations.size() != 0);
   endtask

   // Compare each result transfer with the oldest expected rotation.
   always @(posedge clock) begin : check_results
      rotation_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rotations.size() == 0) begin
            note_mismatch($sformatf("result (%0d,%0d) with no rotation pending",
                                    rsp_x_out, rsp_y_out));
         end else begin
            want = pending_rotations.pop_front();
            results_checked++;
            if (rsp_x_out !== want.x_out) begin
               note_mismatch($sformatf("x_out for (%0d,%0d) by %0d: got %0d, want %0d",
                                       want.x_in, want.y_in, want.angle, rsp_x_out,
                                       want.x_out));
            end
            if (rsp_y_out !== want.y_out) begin
               note_mismatch($sformatf("y_out for (%0d,%0d) by %0d: got %0d, want %0d",
                                       want.x_in, want.y_in, want.angle, rsp_y_out,
                                       want.y_out));
            end
         end
      end
   end

   // Result-side stall: a counted hold-off when one is requested, random otherwise.
   always @(posedge clock) begin
      if (stall_hold_left > 0) begin
         rsp_stall       <= 1'b1;
         stall_hold_left <= stall_hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Random component, leaning on the extremes and on values near zero now and then.
   function automatic int random_component();
      int val;
      case ($urandom_range(7))
         0:       val = -32768;
         1:       val = 32767;
         2:       val = int'($urandom_range(2)) - 1;
         default: val = int'($urandom_range(65535)) - 32768;
      endcase
      return val;
   endfunction

   // Random angle from the full range, within two turns, near and on quarter turns, and small fractions.
   function automatic int random_angle();
      int quarters;
      int deg;
      quarters = int'($urandom_range(2912)) - 1456;
      case ($urandom_range(5))
         0, 1: deg = int'($urandom_range(16777215)) - 8388608;
         2:    deg = int'($urandom_range(92160)) - 46080;
         3:    deg = quarters * int'(TURN_QUARTER);
         4:    deg = quarters * int'(TURN_QUARTER) + int'($urandom_range(6)) - 3;
         default: deg = int'($urandom_range(2 * DEG_ONE)) - DEG_ONE;
      endcase
      return deg;
   endfunction

   // Extreme components at zero and at diagonal angles, and a zero vector at an off-diagonal angle.
   task automatic test_corner_vectors();
      offer_vector(-32768, -32768, 0);
      offer_vector(32767, 32767, 0);
      offer_vector(-32768, 32767, 45 * DEG_ONE);
      offer_vector(32767, -32768, 45 * DEG_ONE);
      offer_vector(32767, 32767, 45 * DEG_ONE);
      offer_vector(-32768, -32768, -45 * DEG_ONE);
      offer_vector(0, 0, 30 * DEG_ONE + 17);
   endtask

   // Quarter and whole turns taken exactly, the angle extremes, and angles just off a turn.
   task automatic test_turn_reduction();
      offer_vector(-32768, 32767, 90 * DEG_ONE);
      offer_vector(-32768, 32767, -90 * DEG_ONE);
      offer_vector(-32768, -32768, 180 * DEG_ONE);
      offer_vector(12345, -6789, -180 * DEG_ONE);
      offer_vector(32767, -32768, 270 * DEG_ONE);
      offer_vector(12345, -6789, 360 * DEG_ONE);
      offer_vector(12345, -6789, -360 * DEG_ONE);
      offer_vector(-32768, 1, 364 * 360 * DEG_ONE);
      offer_vector(1, -32768, -364 * 360 * DEG_ONE);
      offer_vector(32767, -32768, 8388607);
      offer_vector(-32768, 32767, -8388608);
      offer_vector(-32768, 32767, 90 * DEG_ONE + 1);
      offer_vector(32767, -32768, -90 * DEG_ONE - 1);
      offer_vector(-20000, 30000, 180 * DEG_ONE + 1);
      offer_vector(-20000, 30000, -180 * DEG_ONE + 1);
      offer_vector(32767, 32767, 1);
      offer_vector(-32768, -32768, -1);
   endtask

   // Random vectors and angles with the given idle rates on each side.
   task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) offer_vector(random_component(), random_component(), random_angle());
      wait_all_returned();
   endtask

   // Long result-side hold-off while the input keeps coming, so the pipeline fills.
   task automatic test_output_backpressure();
      send_idle_pct   = 0;
      recv_idle_pct   = 0;
      stall_hold_left <= 150;
      repeat (80) offer_vector(random_component(), random_component(), random_angle());
      wait_all_returned();
   endtask

   // Bursts separated by a full drain of the pipeline.
   task automatic test_drain_pause();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (30) offer_vector(random_component(), random_component(), random_angle());
      wait_all_returned();
      repeat (30) offer_vector(random_component(), random_component(), random_angle());
      wait_all_returned();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_vectors();
      test_turn_reduction();
      wait_all_returned();
      test_random_traffic(600, 21, 62);
      test_random_traffic(600, 62, 21);
      test_output_backpressure();
      test_drain_pause();
      test_random_traffic(550, 0, 0);

      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (pending_rotations.size() != 0) begin
         note_mismatch($sformatf("%0d rotations never returned", pending_rotations.size()));
      end

      $display("Rotated %0d vectors over corner, turn-reduction, random and stall phases;",
               items_sent);
      $display("checked %0d results, saw %0d input stall cycles, %0d mismatches.",
               results_checked, input_stalls, mismatch_count);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
